// File: rtl/dpet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed periodic event timer package
// Shared codes, widths and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package dpet_pkg;

  // Field widths.
  localparam int unsigned CfgW     = 31;
  localparam int unsigned DtW      = 32;
  localparam int unsigned GoalW    = 32;
  localparam int unsigned ElapsedW = 33;
  localparam int unsigned CountW   = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // The restoring divider produces one quotient bit per step.
  localparam int unsigned DivSteps = ElapsedW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Operation codes.
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SERVICE = 2'd1;
  localparam logic [1:0] OP_SET     = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Run status codes.
  localparam logic [1:0] ST_PLAY    = 2'd0;
  localparam logic [1:0] ST_PAUSED  = 2'd1;
  localparam logic [1:0] ST_ABORTED = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DELAY = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PERIOD      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOOPED      = 2'd2;

  // Configuration reset values.
  localparam logic [CfgW-1:0] FIRST_DELAY_RST = '0;
  localparam logic [CfgW-1:0] PERIOD_RST      = 31'd1000;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FIN
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted beat and the current goal
    logic start_div;    // seed the divider with the new elapsed time
    logic div_step;     // one restoring division step
    logic commit_exec;  // write back an operation that needs no division
    logic commit_div;   // write back the result of an expiry
  } dpet_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;     // the tick reached the goal and must divide
  } dpet_sts_t;

endpackage

// File: rtl/dpet_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed periodic event timer controller
// Sequences one item at a time through execute, divide and write back, and
// owns the input stall and the output valid flag.
// ----------------------------------------------------------------------------
module dpet_ctrl
  import dpet_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dpet_sts_t sts_i,
  output dpet_cmd_t cmd_o
);

  ctrl_state_e         state_q, state_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;
  logic                div_last;

  // The result register can take a new beat when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (cnt_q == DivCntW'(DivSteps - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_div) begin
          state_d = S_DIV;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs and commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.start_div   = sts_i.need_div;
        cmd_o.commit_exec = !sts_i.need_div && out_free;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_FIN: begin
        cmd_o.commit_div = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Step counter for the divider.
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_o.start_div) begin
      cnt_d = '0;
    end else if (cmd_o.div_step) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // Output valid flag follows result loads and downstream takes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit_exec || cmd_o.commit_div) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/dpet_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed periodic event timer datapath
// Holds configuration, timer state, the captured beat, a restoring divider
// for expiries, and the result register.
// ----------------------------------------------------------------------------
module dpet_dp
  import dpet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input beat
  input  logic [1:0]          operation_i,
  input  logic [DtW-1:0]      dt_i,
  input  logic                call_once_i,
  input  logic [1:0]          new_status_i,
  // Result beat
  output logic [1:0]          status_o,
  output logic [CountW-1:0]   pending_count_o,
  output logic                ready_res_o,
  output logic [CountW-1:0]   fire_count_o,
  // Control
  input  dpet_cmd_t           cmd_i,
  output dpet_sts_t           sts_o
);

  // Configuration registers
  logic [CfgW-1:0] first_delay_q;
  logic [CfgW-1:0] period_q;
  logic            looped_q;

  // Timer state
  logic [1:0]          status_q, status_d;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d;
  logic                phase_q, phase_d;
  logic [CountW-1:0]   pending_q, pending_d;

  // Captured beat and goal
  logic [1:0]       op_q;
  logic [DtW-1:0]   dt_q;
  logic             once_q;
  logic [1:0]       ns_q;
  logic [GoalW-1:0] goal_q, goal_d;

  // Divider
  logic [ElapsedW-1:0] quo_q;
  logic [GoalW-1:0]    rem_q;
  logic [ElapsedW-1:0] trial;
  logic [ElapsedW-1:0] trial_sub;
  logic                trial_ge;

  // Results of operations that need no division
  logic [ElapsedW:0]   sum_full;
  logic [ElapsedW-1:0] sum;
  logic                playing;
  logic [1:0]          ex_status;
  logic [ElapsedW-1:0] ex_elapsed;
  logic                ex_phase;
  logic [CountW-1:0]   ex_pending;
  logic [CountW-1:0]   ex_fire;

  // Expiry write-back
  logic [CountW+1:0]   pend_sum;
  logic [CountW-1:0]   div_pending;

  logic [CfgW-1:0]     period_eff;
  logic                commit;

  assign commit = cmd_i.commit_exec || cmd_i.commit_div;

  // Configuration write port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_delay_q <= FIRST_DELAY_RST;
      period_q      <= PERIOD_RST;
      looped_q      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIRST_DELAY: first_delay_q <= cfg_data_i[CfgW-1:0];
        CFG_PERIOD:      period_q      <= cfg_data_i[CfgW-1:0];
        CFG_LOOPED:      looped_q      <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Goal for the next expiry; a zero period counts as one.
  always_comb begin
    period_eff = (period_q == '0) ? CfgW'(1) : period_q;
    if (phase_q) begin
      goal_d = GoalW'(first_delay_q) + GoalW'(period_eff);
    end else begin
      goal_d = GoalW'(period_eff);
    end
  end

  // Capture the accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      dt_q   <= dt_i;
      once_q <= call_once_i;
      ns_q   <= new_status_i;
      goal_q <= goal_d;
    end
  end

  // Elapsed time after a tick, wrapped to its width.
  assign sum_full = {1'b0, elapsed_q} + (ElapsedW + 1)'(dt_q);
  assign sum      = sum_full[ElapsedW-1:0];
  assign playing  = (status_q == ST_PLAY);

  assign sts_o.need_div = (op_q == OP_TICK) && playing &&
                          (sum >= ElapsedW'(goal_q));

  // Operations that need no division.
  always_comb begin
    ex_status  = status_q;
    ex_elapsed = elapsed_q;
    ex_phase   = phase_q;
    ex_pending = pending_q;
    ex_fire    = '0;
    case (op_q)
      OP_TICK: begin
        if (playing) begin
          ex_elapsed = sum;
        end
      end
      OP_SERVICE: begin
        if (playing) begin
          ex_pending = '0;
          if (!looped_q) begin
            ex_status = ST_ABORTED;
            ex_fire   = CountW'(1);
          end else if (once_q) begin
            ex_fire = CountW'(1);
          end else begin
            ex_fire = pending_q;
          end
        end
      end
      OP_SET: begin
        if (ns_q <= ST_ABORTED) begin
          ex_status = ns_q;
        end
      end
      OP_RESTART: begin
        ex_status  = ST_PLAY;
        ex_elapsed = '0;
        ex_phase   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Restoring division step: shift in the next dividend bit and subtract.
  assign trial     = {rem_q, quo_q[ElapsedW-1]};
  assign trial_ge  = (trial >= ElapsedW'(goal_q));
  assign trial_sub = trial - ElapsedW'(goal_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_div) begin
      quo_q <= sum;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[ElapsedW-2:0], trial_ge};
      rem_q <= trial_ge ? trial_sub[GoalW-1:0] : trial[GoalW-1:0];
    end
  end

  // Pending count grows by the quotient and saturates.
  assign pend_sum    = (CountW + 2)'(pending_q) + (CountW + 2)'(quo_q);
  assign div_pending = (pend_sum[CountW+1:CountW] != 2'b00) ? '1 :
                       pend_sum[CountW-1:0];

  // Write-back selection.
  always_comb begin
    if (cmd_i.commit_div) begin
      status_d  = status_q;
      elapsed_d = ElapsedW'(rem_q);
      phase_d   = 1'b0;
      pending_d = div_pending;
    end else begin
      status_d  = ex_status;
      elapsed_d = ex_elapsed;
      phase_d   = ex_phase;
      pending_d = ex_pending;
    end
  end

  // Timer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= ST_PLAY;
      elapsed_q <= '0;
      phase_q   <= 1'b1;
      pending_q <= '0;
    end else if (commit) begin
      status_q  <= status_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
      pending_q <= pending_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_o        <= status_d;
      pending_count_o <= pending_d;
      ready_res_o     <= (status_d == ST_PLAY) && (pending_d != '0);
      fire_count_o    <= cmd_i.commit_div ? '0 : ex_fire;
    end
  end

endmodule

// File: rtl/delayed_periodic_event_timer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed periodic event timer
// Periodic timer with an initial delay that counts missed expiries and
// services them on request.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (operation, dt, call_once, new_status) are taken when
//   in_valid_i is high and in_stall_o is low. Each beat produces exactly one
//   result beat (status, pending_count, ready_res, fire_count), taken when
//   out_valid_o is high and out_stall_i is low.
//   Configuration is written through cfg_valid_i/cfg_ready_o with a register
//   index (0 first delay, 1 period, 2 looped); cfg_ready_o is always high,
//   and writes belong to idle periods.
//   One item is worked on at a time. Service, set, restart and ticks that do
//   not reach the goal go straight from execute to write-back. A tick that
//   reaches the goal runs the serial restoring divider, one quotient bit per
//   cycle, and then writes back its result.
//   The result register sits between the two sides: a new beat is accepted
//   while a result waits, and only the write-back waits on out_stall_i.
//   Reset clears the timer to playing, elapsed zero, first phase, nothing
//   pending, and loads the default configuration.
// ----------------------------------------------------------------------------
module delayed_periodic_event_timer_top
  import dpet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic [DtW-1:0]      dt_i,
  input  logic                call_once_i,
  input  logic [1:0]          new_status_i,
  // Output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [CountW-1:0]   pending_count_o,
  output logic                ready_res_o,
  output logic [CountW-1:0]   fire_count_o
);

  dpet_cmd_t cmd;
  dpet_sts_t sts;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  dpet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dpet_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .operation_i     (operation_i),
    .dt_i            (dt_i),
    .call_once_i     (call_once_i),
    .new_status_i    (new_status_i),
    .status_o        (status_o),
    .pending_count_o (pending_count_o),
    .ready_res_o     (ready_res_o),
    .fire_count_o    (fire_count_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed periodic event timer testbench
// Walks a short table of directed beats and configuration writes, then
// several phases of random beats under different timer settings. Each
// accepted beat is run through a local model of the timer. Every result beat
// is compared with the oldest expected result. Both sides idle and stall at
// random, except in two phases that run without gaps or stalls.
// ----------------------------------------------------------------------------
module tb
  import dpet_pkg::*;
();

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned MaxIdle    = 8;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseBeats = 135;
  localparam int unsigned ReportMax  = 10;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [DtW-1:0]    DtMax    = '1;
  // A status code outside the defined set, which a set operation ignores.
  localparam logic [1:0] StatusBad = 2'd3;

  typedef struct {
    logic [1:0]     op;
    logic [DtW-1:0] dt;
    logic           once;
    logic [1:0]     ns;
  } timer_beat_t;

  typedef struct {
    logic [1:0]        status;
    logic [CountW-1:0] pending;
    logic              ready;
    logic [CountW-1:0] fired;
  } timer_result_t;

  // One row of the directed table: a register write or a beat, with an
  // optional hand-written expected result.
  typedef struct {
    bit                  is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    timer_beat_t         beat;
    bit                  typed;
    timer_result_t       res;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i  = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [CfgDataW-1:0] cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [1:0]          operation_i  = OP_TICK;
  logic [DtW-1:0]      dt_i         = '0;
  logic                call_once_i  = 1'b0;
  logic [1:0]          new_status_i = ST_PLAY;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [1:0]          status_o;
  logic [CountW-1:0]   pending_count_o;
  logic                ready_res_o;
  logic [CountW-1:0]   fire_count_o;

  // Local copy of the timer configuration and state.
  logic [CfgW-1:0]     cfg_delay;
  logic [CfgW-1:0]     cfg_period;
  logic                cfg_looped;
  logic [1:0]          tm_status;
  logic [ElapsedW-1:0] tm_elapsed;
  logic                tm_first;
  logic [CountW-1:0]   tm_pending;

  timer_result_t awaited_results[$];
  plan_row_t     plan[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles     = 0;
  int unsigned   stall_left = 0;
  bit            quiet      = 1'b0;

  delayed_periodic_event_timer_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .dt_i           (dt_i),
    .call_once_i    (call_once_i),
    .new_status_i   (new_status_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .pending_count_o(pending_count_o),
    .ready_res_o    (ready_res_o),
    .fire_count_o   (fire_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The goal includes the initial delay until the first expiry.
  function automatic logic [GoalW-1:0] current_goal();
    logic [GoalW-1:0] per;
    per = (cfg_period == '0) ? 32'd1 : {1'b0, cfg_period};
    return tm_first ? per + {1'b0, cfg_delay} : per;
  endfunction

  // Advances the local timer by one beat and returns the result it causes.
  function automatic timer_result_t compute_timer_result(timer_beat_t b);
    timer_result_t    r;
    logic [GoalW-1:0] goal;
    logic [63:0]      total;
    r.fired = '0;
    case (b.op)
      OP_TICK: begin
        if (tm_status == ST_PLAY) begin
          tm_elapsed = tm_elapsed + {1'b0, b.dt};
          goal = current_goal();
          if (tm_elapsed >= {1'b0, goal}) begin
            total = 64'(tm_pending) + 64'(tm_elapsed / {1'b0, goal});
            tm_pending = (total > 64'(CountMax)) ? CountMax : total[CountW-1:0];
            tm_elapsed = tm_elapsed % {1'b0, goal};
            tm_first = 1'b0;
          end
        end
      end
      OP_SERVICE: begin
        if (tm_status == ST_PLAY) begin
          if (!cfg_looped) begin
            // One-shot: fire once and abort.
            r.fired = 32'd1;
            tm_status = ST_ABORTED;
          end else if (b.once) begin
            r.fired = 32'd1;
          end else begin
            r.fired = tm_pending;
          end
          tm_pending = '0;
        end
      end
      OP_SET: begin
        if (b.ns <= ST_ABORTED) tm_status = b.ns;
      end
      OP_RESTART: begin
        tm_status = ST_PLAY;
        tm_elapsed = '0;
        tm_first = 1'b1;
      end
      default: ;
    endcase
    r.status = tm_status;
    r.pending = tm_pending;
    r.ready = (tm_status == ST_PLAY) && (tm_pending != '0);
    return r;
  endfunction

  function automatic void add_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    row.typed = 1'b0;
    plan.push_back(row);
  endfunction

  function automatic void add_beat(logic [1:0] op, logic [DtW-1:0] dt, logic once,
                                   logic [1:0] ns, bit typed = 1'b0,
                                   logic [1:0] st = ST_PLAY, logic [CountW-1:0] pend = '0,
                                   logic rdy = 1'b0, logic [CountW-1:0] fire = '0);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.beat.op = op;
    row.beat.dt = dt;
    row.beat.once = once;
    row.beat.ns = ns;
    row.typed = typed;
    row.res.status = st;
    row.res.pending = pend;
    row.res.ready = rdy;
    row.res.fired = fire;
    plan.push_back(row);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= ReportMax) $display("%s", msg);
  endfunction

  // Lowers valid and waits until every expected result beat has come.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it into the local configuration.
  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FIRST_DELAY: cfg_delay = data[CfgW-1:0];
      CFG_PERIOD:      cfg_period = data[CfgW-1:0];
      CFG_LOOPED:      cfg_looped = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Sends one beat after a random gap and queues its expected result.
  task automatic send_beat(input timer_beat_t b, input bit typed, input timer_result_t fixed);
    int unsigned   gap;
    timer_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, MaxIdle);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = b.op;
    dt_i = b.dt;
    call_once_i = b.once;
    new_status_i = b.ns;
    do @(posedge clk_i); while (in_stall_o);
    predicted = compute_timer_result(b);
    awaited_results.push_back(typed ? fixed : predicted);
  endtask

  // Result side: hold stall for the drawn number of cycles.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin : watch_results
    timer_result_t want;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      stall_left = quiet ? 0 : $urandom_range(0, MaxIdle);
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d pending %0d ready %0d fired %0d",
                                status_o, pending_count_o, ready_res_o, fire_count_o));
      end else begin
        want = awaited_results.pop_front();
        if (status_o !== want.status || pending_count_o !== want.pending ||
            ready_res_o !== want.ready || fire_count_o !== want.fired) begin
          note_mismatch($sformatf({"result mismatch: expected status %0d pending %0d ",
                                   "ready %0d fired %0d, got status %0d pending %0d ",
                                   "ready %0d fired %0d"},
                                  want.status, want.pending, want.ready, want.fired,
                                  status_o, pending_count_o, ready_res_o, fire_count_o));
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin : main
    timer_beat_t         b;
    timer_result_t       none;
    logic [GoalW-1:0]    goal;
    logic [63:0]         span;
    int unsigned         sel;
    logic [CfgDataW-1:0] d_delay;
    logic [CfgDataW-1:0] d_period;
    logic [CfgDataW-1:0] d_looped;

    none.status = ST_PLAY;
    none.pending = '0;
    none.ready = 1'b0;
    none.fired = '0;

    // Local timer after reset.
    cfg_delay = FIRST_DELAY_RST;
    cfg_period = PERIOD_RST;
    cfg_looped = 1'b1;
    tm_status = ST_PLAY;
    tm_elapsed = '0;
    tm_first = 1'b1;
    tm_pending = '0;

    // Directed table, starting from the reset settings.
    add_beat(OP_SERVICE, '0, 1'b0, ST_PLAY, 1, ST_PLAY, '0, 1'b0, '0);      // drain of nothing
    add_beat(OP_TICK, 32'd999, 1'b0, ST_PLAY, 1, ST_PLAY, '0, 1'b0, '0);    // just short
    add_beat(OP_TICK, 32'd1, 1'b0, ST_PLAY, 1, ST_PLAY, 32'd1, 1'b1, '0);   // exact goal
    add_beat(OP_TICK, DtMax, 1'b0, ST_PLAY);                                // many missed
    add_beat(OP_SERVICE, '0, 1'b0, ST_PLAY);                                // drain all
    add_beat(OP_SET, '0, 1'b0, ST_PAUSED, 1, ST_PAUSED, '0, 1'b0, '0);
    add_beat(OP_TICK, 32'd5000, 1'b0, ST_PLAY, 1, ST_PAUSED, '0, 1'b0, '0); // paused tick
    add_beat(OP_SERVICE, '0, 1'b1, ST_PLAY, 1, ST_PAUSED, '0, 1'b0, '0);    // paused service
    add_beat(OP_SET, '0, 1'b0, StatusBad, 1, ST_PAUSED, '0, 1'b0, '0);      // ignored code
    add_beat(OP_SET, '0, 1'b0, ST_PLAY, 1, ST_PLAY, '0, 1'b0, '0);
    add_beat(OP_TICK, 32'd2500, 1'b0, ST_PLAY);
    add_beat(OP_SERVICE, '0, 1'b1, ST_PLAY, 1, ST_PLAY, '0, 1'b0, 32'd1);   // fire once
    add_beat(OP_SERVICE, '0, 1'b1, ST_PLAY, 1, ST_PLAY, '0, 1'b0, 32'd1);   // once, none due
    add_beat(OP_SET, '0, 1'b0, ST_ABORTED, 1, ST_ABORTED, '0, 1'b0, '0);
    add_beat(OP_RESTART, '0, 1'b0, ST_PLAY, 1, ST_PLAY, '0, 1'b0, '0);
    // A zero period acts as one, which drives the pending count to saturation.
    add_cfg(CFG_PERIOD, '0);
    add_beat(OP_TICK, DtMax, 1'b0, ST_PLAY, 1, ST_PLAY, CountMax, 1'b1, '0);
    add_beat(OP_TICK, DtMax, 1'b0, ST_PLAY, 1, ST_PLAY, CountMax, 1'b1, '0);
    add_beat(OP_SET, '0, 1'b0, ST_PAUSED, 1, ST_PAUSED, CountMax, 1'b0, '0);
    add_beat(OP_RESTART, '0, 1'b0, ST_PLAY, 1, ST_PLAY, CountMax, 1'b1, '0); // pending kept
    // One-shot timer.
    add_cfg(CFG_LOOPED, 32'd0);
    add_beat(OP_SERVICE, '0, 1'b0, ST_PLAY, 1, ST_ABORTED, '0, 1'b0, 32'd1);
    add_beat(OP_TICK, 32'd7, 1'b0, ST_PLAY, 1, ST_ABORTED, '0, 1'b0, '0);
    add_beat(OP_RESTART, '0, 1'b0, ST_PLAY, 1, ST_PLAY, '0, 1'b0, '0);
    // Largest delay and period; the period write also has the unused top bit set.
    add_cfg(CFG_FIRST_DELAY, 32'h7FFF_FFFF);
    add_cfg(CFG_PERIOD, 32'hFFFF_FFFF);
    add_cfg(CFG_LOOPED, 32'd1);
    add_beat(OP_TICK, DtMax, 1'b0, ST_PLAY);
    add_beat(OP_TICK, DtMax, 1'b0, ST_PLAY);
    add_beat(OP_SERVICE, '0, 1'b0, ST_PLAY);

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_cfg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].res);
      end
    end

    // Random phases, each under its own timer settings.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      d_looped = 32'd1;
      case (phase)
        0: begin
          d_delay = '0;
          d_period = 32'd1;
        end
        1: begin
          d_delay = 32'h7FFF_FFFF;
          d_period = 32'h7FFF_FFFF;
        end
        2: begin
          d_delay = $urandom_range(0, 200);
          d_period = $urandom_range(1, 100);
        end
        3: begin
          d_delay = $urandom;
          d_period = $urandom;
          d_looped = 32'd0;
        end
        4: begin
          d_delay = $urandom_range(0, 1000);
          d_period = $urandom_range(1, 50);
        end
        5: begin
          // Only the top bit set: the period register reads as zero.
          d_delay = $urandom_range(0, 50);
          d_period = 32'h8000_0000;
          d_looped = $urandom_range(0, 1);
        end
        6: begin
          d_delay = $urandom;
          d_period = $urandom_range(1, 5000);
        end
        default: begin
          d_delay = '0;
          d_period = 32'd1000;
          d_looped = $urandom_range(0, 1);
        end
      endcase
      write_cfg(CFG_FIRST_DELAY, d_delay);
      write_cfg(CFG_PERIOD, d_period);
      write_cfg(CFG_LOOPED, d_looped);
      quiet = (phase == 0) || (phase == 4);

      for (int unsigned n = 0; n < PhaseBeats; n++) begin
        // Now and then let the timer run dry before the next beat.
        if ($urandom_range(0, 59) == 0) wait_drained();
        sel = $urandom_range(0, 19);
        if (sel <= 10) b.op = OP_TICK;
        else if (sel <= 14) b.op = OP_SERVICE;
        else if (sel <= 17) b.op = OP_SET;
        else b.op = OP_RESTART;
        b.once = 1'($urandom_range(0, 1));
        b.ns = ($urandom_range(0, 4) < 3) ? ST_PLAY : 2'($urandom_range(0, 3));
        // Tick sizes relative to the goal: below and around it, exact hits, tiny, huge.
        goal = current_goal();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            span = 64'(goal) * 2;
            if (span > 64'(DtMax)) span = 64'(DtMax);
            b.dt = $urandom_range(0, 32'(span));
          end
          4, 5: b.dt = 32'(64'(goal) - 64'(tm_elapsed) - 1 + 64'($urandom_range(0, 2)));
          6, 7: b.dt = $urandom;
          default: b.dt = $urandom_range(0, 3);
        endcase
        send_beat(b, 1'b0, none);
      end
    end

    quiet = 1'b0;
    wait_drained();
    repeat (DivSteps + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dpet_pkg.sv
rtl/dpet_ctrl.sv
rtl/dpet_dp.sv
rtl/delayed_periodic_event_timer_top.sv
tb/tb.sv
